// ===== design/keyed_record_stack_top_defines.svh =====
// ----------------------------------------------------------------------------
// keyed_record_stack_top_defines.svh
// Assertion macros of the record stack top design file.
// ----------------------------------------------------------------------------
`ifndef KEYED_RECORD_STACK_TOP_DEFINES_SVH
`define KEYED_RECORD_STACK_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define KRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("krs assertion failed");

// next-cycle implication, checked out of reset
`define KRS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("krs assertion failed");

`endif

// ===== design/krs_pkg.sv =====
// ----------------------------------------------------------------------------
// krs_pkg
// Types and codes of the keyed record stack.
// ----------------------------------------------------------------------------
package krs_pkg;

    localparam int ID_W    = 16;
    localparam int NAME_W  = 64;
    localparam int PRICE_W = 32;
    localparam int QTY_W   = 16;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_SEARCH = 2'd2,
        OP_DUMP   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [NAME_W-1:0]  name;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   quantity;
    } t_record;

    typedef struct packed {
        t_status status;
        t_record rec;
        logic    last;
    } t_result;

endpackage

// ===== design/krs_if.sv =====
// ----------------------------------------------------------------------------
// krs_if
// Request and response channels of the keyed record stack.
// ----------------------------------------------------------------------------
interface krs_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] item_id;
    logic [63:0] item_name;
    logic [31:0] item_price;
    logic [15:0] item_quantity;

    modport source (output valid, opcode, item_id, item_name, item_price, item_quantity,
                    input ready);
    modport sink   (input valid, opcode, item_id, item_name, item_price, item_quantity,
                    output ready);
endinterface

interface krs_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] out_id;
    logic [63:0] out_name;
    logic [31:0] out_price;
    logic [15:0] out_quantity;
    logic        last;

    modport source (output valid, status, out_id, out_name, out_price, out_quantity, last,
                    input ready);
    modport sink   (input valid, status, out_id, out_name, out_price, out_quantity, last,
                    output ready);
endinterface

// ===== design/krs_ram.sv =====
// ----------------------------------------------------------------------------
// krs_ram
// Record memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module krs_ram
    import krs_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_record       i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_record       o_rdata
);

    t_record r_mem [DEPTH];
    t_record r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/keyed_record_stack_top.sv =====
// ----------------------------------------------------------------------------
// keyed_record_stack_top
// Bounded LIFO of records with push, pop, search by id and dump.
//
//   channel  dir  handshake        payload
//   i_req    in   valid / ready    opcode, item_id, item_name, item_price,
//                                  item_quantity
//   o_rsp    out  valid / ready    status, out_id, out_name, out_price,
//                                  out_quantity, last
//
// Push and pop go from the idle state straight to the response state. Search
// reads one stored record per cycle from the top through the single memory read
// port and compares ids in one comparator until a match or the bottom record,
// then responds. Dump emits one record per response, each read in scan state.
// One request at a time; i_req.ready is low until its last response is taken.
// Reset clears the record count; memory contents are not cleared.
// ----------------------------------------------------------------------------
`include "keyed_record_stack_top_defines.svh"

module keyed_record_stack_top
    import krs_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    krs_req_if.sink   i_req,
    krs_rsp_if.source o_rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_ptr,   n_ptr;
    t_op           r_op,    n_op;
    logic [ID_W-1:0] r_key, n_key;
    t_result       r_out,   n_out;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_record       w_wdata;
    t_record       w_rdata;

    logic w_acc, w_taken, w_full, w_empty, w_match, w_ptr_zero, w_scan_op;
    t_op  w_req_op;

    assign w_req_op   = t_op'(i_req.opcode);
    assign w_acc      = i_req.valid && i_req.ready;
    assign w_taken    = o_rsp.valid && o_rsp.ready;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_match    = (w_rdata.id == r_key);
    assign w_ptr_zero = (r_ptr == '0);
    assign w_scan_op  = (w_req_op == OP_SEARCH) || (w_req_op == OP_DUMP);

    assign w_wdata = '{id: i_req.item_id, name: i_req.item_name,
                       price: i_req.item_price, quantity: i_req.item_quantity};

    krs_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (n_ptr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_state = (w_scan_op && !w_empty) ? S_SCAN : S_OUT;
                end
            end
            S_SCAN: begin
                if (r_op == OP_DUMP || w_match || w_ptr_zero) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_taken) begin
                    n_state = (r_op == OP_DUMP && !r_out.last) ? S_SCAN : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count = r_count;
        n_ptr   = r_ptr;
        n_op    = r_op;
        n_key   = r_key;
        n_out   = r_out;
        w_we    = 1'b0;
        w_waddr = r_count[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_op   = w_req_op;
                    n_key  = i_req.item_id;
                    n_ptr  = AW'(r_count - CW'(1));
                    n_out  = '{status: ST_OK, rec: '0, last: 1'b1};
                    unique case (w_req_op)
                        OP_PUSH: begin
                            if (w_full) begin
                                n_out.status = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        OP_POP: begin
                            if (w_empty) begin
                                n_out.status = ST_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        OP_SEARCH, OP_DUMP: begin
                            if (w_empty) begin
                                n_out.status = ST_EMPTY;
                            end
                        end
                        default: n_out.status = ST_OK;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_op == OP_DUMP) begin
                    n_out = '{status: ST_OK, rec: w_rdata, last: w_ptr_zero};
                end else if (w_match) begin
                    n_out = '{status: ST_OK, rec: w_rdata, last: 1'b1};
                end else if (w_ptr_zero) begin
                    n_out = '{status: ST_NOTFOUND, rec: '0, last: 1'b1};
                end else begin
                    n_ptr = r_ptr - AW'(1);
                end
            end
            S_OUT: begin
                if (w_taken && r_op == OP_DUMP && !r_out.last) begin
                    n_ptr = r_ptr - AW'(1);
                end
            end
            default: n_out = r_out;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_op  <= n_op;
        r_key <= n_key;
        r_out <= n_out;
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = (r_state == S_OUT);
    assign o_rsp.status       = r_out.status;
    assign o_rsp.out_id       = r_out.rec.id;
    assign o_rsp.out_name     = r_out.rec.name;
    assign o_rsp.out_price    = r_out.rec.price;
    assign o_rsp.out_quantity = r_out.rec.quantity;
    assign o_rsp.last         = r_out.last;

    `KRS_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `KRS_ASSERT_IMP(a_rsp_blocks_req, i_clk, i_rst_n, o_rsp.valid, !i_req.ready)
    `KRS_ASSERT_IMP(a_scan_in_range, i_clk, i_rst_n, r_state == S_SCAN, CW'(r_ptr) < r_count)
    `KRS_ASSERT_NXT(a_push_grows, i_clk, i_rst_n, w_acc && w_req_op == OP_PUSH && !w_full, r_count == $past(r_count) + CW'(1))

endmodule

// ===== verif/tb_keyed_record_stack_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyed_record_stack_top
// Self-checking bench for the keyed record stack. A scoreboard keeps its own
// copy of the stack, predicts every response of each accepted request and
// compares the responses field by field in order. Directed requests cover
// empty, full, duplicate-id and not-found cases. Random phases then fill,
// drain or balance the stack, with random idle gaps on both channels.
// ----------------------------------------------------------------------------
module tb_keyed_record_stack_top;
    import krs_pkg::*;

    localparam int STACK_DEPTH     = 16;
    localparam int RESET_CYCLES    = 11;
    localparam int RANDOM_REQUESTS = 450;
    localparam int PHASE_LEN       = 30;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = STACK_DEPTH + 8;

    class krs_scoreboard;
        t_record stack_mem [STACK_DEPTH];
        int      stack_fill;
        t_result pending_responses [$];
        int      error_count;
        int      checked_count;
        int      op_count [4];

        function new();
            stack_fill    = 0;
            error_count   = 0;
            checked_count = 0;
            foreach (op_count[i]) op_count[i] = 0;
        endfunction

        // update the stack copy and queue the responses of one request
        function void note_request(t_op op, t_record item);
            t_result r;
            int      idx;
            bit      hit;
            op_count[int'(op)]++;
            r.status = ST_OK;
            r.rec    = '0;
            r.last   = 1'b1;
            case (op)
                OP_PUSH: begin
                    if (stack_fill >= STACK_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        stack_mem[stack_fill] = item;
                        stack_fill++;
                    end
                    pending_responses.push_back(r);
                end
                OP_POP: begin
                    if (stack_fill == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        stack_fill--;
                    end
                    pending_responses.push_back(r);
                end
                OP_SEARCH: begin
                    if (stack_fill == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        hit = 1'b0;
                        for (idx = stack_fill - 1; idx >= 0 && !hit; idx--) begin
                            if (stack_mem[idx].id == item.id) begin
                                r.rec = stack_mem[idx];
                                hit   = 1'b1;
                            end
                        end
                        if (!hit) r.status = ST_NOTFOUND;
                    end
                    pending_responses.push_back(r);
                end
                default: begin
                    if (stack_fill == 0) begin
                        r.status = ST_EMPTY;
                        pending_responses.push_back(r);
                    end else begin
                        for (idx = stack_fill - 1; idx >= 0; idx--) begin
                            r.rec  = stack_mem[idx];
                            r.last = (idx == 0);
                            pending_responses.push_back(r);
                        end
                    end
                end
            endcase
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
                error_count++;
            end
        endfunction

        function void check_response(t_result got);
            t_result want;
            if (pending_responses.size() == 0) begin
                $display("%0t: unexpected response, status %0d id %0h last %0b",
                         $time, got.status, got.rec.id, got.last);
                error_count++;
                return;
            end
            want = pending_responses.pop_front();
            checked_count++;
            compare_field("status",   64'(want.status),       64'(got.status));
            compare_field("id",       64'(want.rec.id),       64'(got.rec.id));
            compare_field("name",     want.rec.name,          got.rec.name);
            compare_field("price",    64'(want.rec.price),    64'(got.rec.price));
            compare_field("quantity", 64'(want.rec.quantity), 64'(got.rec.quantity));
            compare_field("last",     64'(want.last),         64'(got.last));
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    bit   no_idle = 1'b0;
    int   cycle_count;

    krs_scoreboard sb = new();

    krs_req_if req_ch ();
    krs_rsp_if rsp_ch ();

    keyed_record_stack_top #(
        .DEPTH (STACK_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_record random_record();
        t_record rec;
        rec.id       = 16'($urandom);
        rec.name     = {$urandom, $urandom};
        rec.price    = $urandom;
        rec.quantity = 16'($urandom);
        return rec;
    endfunction

    function automatic t_record build_record(logic [15:0] id, logic [63:0] name,
                                             logic [31:0] price, logic [15:0] qty);
        t_record rec;
        rec.id       = id;
        rec.name     = name;
        rec.price    = price;
        rec.quantity = qty;
        return rec;
    endfunction

    task automatic send_request(input t_op op, input t_record rec);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.opcode        <= op;
        req_ch.item_id       <= rec.id;
        req_ch.item_name     <= rec.name;
        req_ch.item_price    <= rec.price;
        req_ch.item_quantity <= rec.quantity;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(op, rec);
    endtask

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : response_side
        int      stall;
        t_result got;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
            got.status       = t_status'(rsp_ch.status);
            got.rec.id       = rsp_ch.out_id;
            got.rec.name     = rsp_ch.out_name;
            got.rec.price    = rsp_ch.out_price;
            got.rec.quantity = rsp_ch.out_quantity;
            got.last         = rsp_ch.last;
            sb.check_response(got);
        end
    end

    initial begin : stimulus
        t_op     op;
        t_record rec;
        int      roll;
        int      push_pct;
        int      pop_pct;
        int      search_pct;
        req_ch.valid         <= 1'b0;
        req_ch.opcode        <= OP_PUSH;
        req_ch.item_id       <= '0;
        req_ch.item_name     <= '0;
        req_ch.item_price    <= '0;
        req_ch.item_quantity <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty store
        send_request(OP_POP,    random_record());
        send_request(OP_SEARCH, random_record());
        send_request(OP_DUMP,   random_record());
        // field extremes
        send_request(OP_PUSH, build_record('0, '0, '0, '0));
        send_request(OP_PUSH, build_record('1, '1, '1, '1));
        send_request(OP_SEARCH, build_record(16'hffff, '0, '0, '0));
        send_request(OP_SEARCH, build_record(16'h0000, '1, '1, '1));
        // duplicate id: search must return the newer record
        send_request(OP_PUSH, build_record(16'h0000, 64'h414243444546_4748, 32'd1999, 16'd7));
        send_request(OP_SEARCH, build_record(16'h0000, '0, '0, '0));
        send_request(OP_DUMP, random_record());
        // fill to the top, overflow, deep miss, full dump
        while (sb.stack_fill < STACK_DEPTH) begin
            rec = random_record();
            if (rec.id == 16'h1234) rec.id = 16'h4321;
            send_request(OP_PUSH, rec);
        end
        send_request(OP_PUSH, random_record());
        send_request(OP_SEARCH, build_record(16'h1234, '0, '0, '0));
        send_request(OP_DUMP, random_record());

        push_pct   = 38;
        pop_pct    = 70;
        search_pct = 93;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % PHASE_LEN == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 2))
                    0: begin push_pct = 60; pop_pct = 75; search_pct = 94; end
                    1: begin push_pct = 20; pop_pct = 70; search_pct = 94; end
                    default: begin push_pct = 38; pop_pct = 70; search_pct = 93; end
                endcase
            end
            roll = $urandom_range(0, 99);
            if (roll < push_pct)        op = OP_PUSH;
            else if (roll < pop_pct)    op = OP_POP;
            else if (roll < search_pct) op = OP_SEARCH;
            else                        op = OP_DUMP;
            rec = random_record();
            // narrow id pool gives duplicates and hits
            if ($urandom_range(0, 1) == 1) rec.id = 16'($urandom_range(0, 7));
            if (op == OP_SEARCH && sb.stack_fill > 0 && $urandom_range(0, 9) < 7)
                rec.id = sb.stack_mem[$urandom_range(0, sb.stack_fill - 1)].id;
            send_request(op, rec);
        end
        req_ch.valid <= 1'b0;
        no_idle = 1'b0;

        while (sb.pending_responses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests: %0d push, %0d pop, %0d search, %0d dump.",
                 sb.op_count[0] + sb.op_count[1] + sb.op_count[2] + sb.op_count[3],
                 sb.op_count[0], sb.op_count[1], sb.op_count[2], sb.op_count[3]);
        $display("Compared %0d responses field by field, %0d mismatches.",
                 sb.checked_count, sb.error_count);
        if (sb.error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== keyed_record_stack_top.f =====
+incdir+design
design/krs_pkg.sv
design/krs_if.sv
design/krs_ram.sv
design/keyed_record_stack_top.sv
verif/tb_keyed_record_stack_top.sv
